[design/mcct_pkg.sv]
package mcct_pkg;

  // Grid and fixed-point setup
  localparam int GRID_DIM  = 256;
  localparam int FRAC_BITS = 8;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int COORD_W   = 17;
  localparam int NUM_EDGES = 12;
  localparam int MAX_TRIS  = 5;
  localparam int ROW_W     = 4 * 3 * MAX_TRIS;

  // Queue between the classifier pipeline and the emitter
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Edge code that marks an unused slot of a table row
  localparam logic [3:0] EDGE_NONE = 4'hf;

  // Corner offsets along each axis, bit c for corner c
  localparam logic [7:0] OFF_X = 8'b0110_0110;
  localparam logic [7:0] OFF_Y = 8'b1100_1100;
  localparam logic [7:0] OFF_Z = 8'b1111_0000;

  // End corners of each cube edge
  localparam logic [2:0] EDGE_A [NUM_EDGES] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [2:0] EDGE_B [NUM_EDGES] = '{
    3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

  // Triangle table: edge codes, first code in the top nibble, padded with EDGE_NONE
  localparam logic [ROW_W-1:0] TRI_ROM [256] = '{
    60'hfffffffffffffff, 60'h083ffffffffffff, 60'h019ffffffffffff, 60'h183981fffffffff,
    60'h12affffffffffff, 60'h08312afffffffff, 60'h92a029fffffffff, 60'h2832a8a98ffffff,
    60'h3b2ffffffffffff, 60'h0b28b0fffffffff, 60'h19023bfffffffff, 60'h1b219b98bffffff,
    60'h3a1ba3fffffffff, 60'h0a108a8baffffff, 60'h3903b9ba9ffffff, 60'h98aa8bfffffffff,
    60'h478ffffffffffff, 60'h430734fffffffff, 60'h019847fffffffff, 60'h419471731ffffff,
    60'h12a847fffffffff, 60'h34730412affffff, 60'h92a902847ffffff, 60'h2a9297273794fff,
    60'h8473b2fffffffff, 60'hb47b24204ffffff, 60'h90184723bffffff, 60'h47b94b9b2921fff,
    60'h3a13ba784ffffff, 60'h1ba14b1047b4fff, 60'h47890b9bab03fff, 60'h47b4b99baffffff,
    60'h954ffffffffffff, 60'h954083fffffffff, 60'h054150fffffffff, 60'h854835315ffffff,
    60'h12a954fffffffff, 60'h30812a495ffffff, 60'h52a542402ffffff, 60'h2a5325354348fff,
    60'h95423bfffffffff, 60'h0b208b495ffffff, 60'h05401523bffffff, 60'h21525828b485fff,
    60'ha3ba13954ffffff, 60'h4950818a18bafff, 60'h54050b5bab03fff, 60'h54858aa8bffffff,
    60'h978579fffffffff, 60'h930953573ffffff, 60'h078017157ffffff, 60'h153357fffffffff,
    60'h978957a12ffffff, 60'ha12950530573fff, 60'h802825857a52fff, 60'h2a5253357ffffff,
    60'h7957893b2ffffff, 60'h95797292027bfff, 60'h23b018178157fff, 60'hb21b17715ffffff,
    60'h958857a13a3bfff, 60'h5705097b010aba0, 60'hba0b03a50807570, 60'hba57b5fffffffff,
    60'ha65ffffffffffff, 60'h0835a6fffffffff, 60'h9015a6fffffffff, 60'h1831985a6ffffff,
    60'h165261fffffffff, 60'h165126308ffffff, 60'h965906026ffffff, 60'h598582526328fff,
    60'h23ba65fffffffff, 60'hb08b20a65ffffff, 60'h01923b5a6ffffff, 60'h5a61929b298bfff,
    60'h63b653513ffffff, 60'h08b0b50515b6fff, 60'h3b6036065059fff, 60'h65969bb98ffffff,
    60'h5a6478fffffffff, 60'h43047365affffff, 60'h1905a6847ffffff, 60'ha65197173794fff,
    60'h612651478ffffff, 60'h125526304347fff, 60'h847905065026fff, 60'h739794329596269,
    60'h3b2784a65ffffff, 60'h5a647242027bfff, 60'h01947823b5a6fff, 60'h9219b294b7b45a6,
    60'h8473b53515b6fff, 60'h51b5b610b7b404b, 60'h059065036b63847, 60'h65969b4797b9fff,
    60'ha4964afffffffff, 60'h4a649a083ffffff, 60'ha01a60640ffffff, 60'h83181686461afff,
    60'h149124264ffffff, 60'h308129249264fff, 60'h024426fffffffff, 60'h832824426ffffff,
    60'ha49a64b23ffffff, 60'h08228b49a4a6fff, 60'h3b201606461afff, 60'h64161a48121b8b1,
    60'h964936913b63fff, 60'h8b1810b61914641, 60'h3b6360064ffffff, 60'h648b68fffffffff,
    60'h7a678a89affffff, 60'h0730a709a67afff, 60'ha671a7178180fff, 60'ha67a71173ffffff,
    60'h126168189867fff, 60'h269291679093739, 60'h780706602ffffff, 60'h732672fffffffff,
    60'h23ba68a89867fff, 60'h20727b09767a9a7, 60'h1801781a767a23b, 60'hb21b17a61671fff,
    60'h896867916b63136, 60'h091b67fffffffff, 60'h7807063b0b60fff, 60'h7b6ffffffffffff,
    60'h76bffffffffffff, 60'h308b76fffffffff, 60'h019b76fffffffff, 60'h819831b76ffffff,
    60'ha126b7fffffffff, 60'h12a3086b7ffffff, 60'h2902a96b7ffffff, 60'h6b72a3a83a98fff,
    60'h723627fffffffff, 60'h708760620ffffff, 60'h276237019ffffff, 60'h162186198876fff,
    60'ha76a17137ffffff, 60'ha7617a187108fff, 60'h03707a0a96a7fff, 60'h76a7a88a9ffffff,
    60'h684b86fffffffff, 60'h36b306046ffffff, 60'h86b846901ffffff, 60'h946963931b36fff,
    60'h6846b82a1ffffff, 60'h12a30b06b046fff, 60'h4b846b0292a9fff, 60'ha93a32943b36463,
    60'h823842462ffffff, 60'h042462fffffffff, 60'h190234246438fff, 60'h194142246ffffff,
    60'h8138618466a1fff, 60'ha10a06604ffffff, 60'h4634386a3039a93, 60'ha946a4fffffffff,
    60'h49576bfffffffff, 60'h083495b76ffffff, 60'h50154076bffffff, 60'hb76834354315fff,
    60'h954a1276bffffff, 60'h6b712a083495fff, 60'h76b54a42a402fff, 60'h348354325a52b76,
    60'h723762549ffffff, 60'h954086062687fff, 60'h362376150540fff, 60'h628687218485158,
    60'h954a16176137fff, 60'h16a176107870954, 60'h40a4a503a6a737a, 60'h76a7a854a48afff,
    60'h6956b9b89ffffff, 60'h36b063056095fff, 60'h0b805b01556bfff, 60'h6b3635531ffffff,
    60'h12a95b9b8b56fff, 60'h0b306b09656912a, 60'hb85b56805a52025, 60'h6b36352a3a53fff,
    60'h589528562382fff, 60'h956960062ffffff, 60'h158180568382628, 60'h156216fffffffff,
    60'h13616a386569896, 60'ha10a06950560fff, 60'h03856afffffffff, 60'ha56ffffffffffff,
    60'hb5a75bfffffffff, 60'hb5ab75830ffffff, 60'h5b75ab190ffffff, 60'ha75ab7981831fff,
    60'hb12b71751ffffff, 60'h08312717572bfff, 60'h9759279022b7fff, 60'h75272b592328982,
    60'h25a235375ffffff, 60'h820852875a25fff, 60'h9015a35373a2fff, 60'h982921872a25752,
    60'h135375fffffffff, 60'h087071175ffffff, 60'h903935537ffffff, 60'h987597fffffffff,
    60'h5845a8ab8ffffff, 60'h5045b05abb30fff, 60'h01984a8aba45fff, 60'hab4a45b34941314,
    60'h2512852b8458fff, 60'h04b0b345b2b151b, 60'h0250592b5458b85, 60'h9452b3fffffffff,
    60'h25a352345384fff, 60'h5a2524420ffffff, 60'h3a235a385458019, 60'h5a2524192942fff,
    60'h845853351ffffff, 60'h045105fffffffff, 60'h845853905035fff, 60'h945ffffffffffff,
    60'h4b749b9abffffff, 60'h0834979b79abfff, 60'h1ab1b414074bfff, 60'h3143481a474bab4,
    60'h4b79b492b912fff, 60'h9749b791b2b1083, 60'hb74b42240ffffff, 60'hb74b42834324fff,
    60'h29a279237749fff, 60'h9a7974a27870207, 60'h37a3a274a1a040a, 60'h1a2874fffffffff,
    60'h491417713ffffff, 60'h491417081871fff, 60'h403743fffffffff, 60'h487ffffffffffff,
    60'h9a8ab8fffffffff, 60'h30939bb9affffff, 60'h01a0a88abffffff, 60'h31ab3afffffffff,
    60'h12b1b99b8ffffff, 60'h30939b1292b9fff, 60'h02b80bfffffffff, 60'h32bffffffffffff,
    60'h23828aa89ffffff, 60'h9a2092fffffffff, 60'h23828a0181a8fff, 60'h1a2ffffffffffff,
    60'h138918fffffffff, 60'h091ffffffffffff, 60'h038ffffffffffff, 60'hfffffffffffffff
  };

  // One classified cell, waiting to be emitted
  typedef struct packed {
    logic [7:0]                           idx;
    logic [7:0]                           cx;
    logic [7:0]                           cy;
    logic [7:0]                           cz;
    logic [NUM_EDGES-1:0][FRAC_W-1:0]     frac;
  } entry_t;

  // One triangle beat
  typedef struct packed {
    logic [2:0][2:0][COORD_W-1:0] vtx;     // [vertex][axis], axis 0 is x
    logic [2:0]                   tri_number;
    logic                         last;
  } tri_t;

  // Number of triangles for a cube index
  function automatic logic [2:0] tri_count(input logic [7:0] idx);
    logic [ROW_W-1:0] row;
    logic [2:0]       n;
    row = TRI_ROM[idx];
    n = 3'd0;
    for (int k = 0; k < MAX_TRIS; k++) begin
      if (row[ROW_W-1-12*k -: 4] != EDGE_NONE) n = n + 3'd1;
    end
    return n;
  endfunction

  // Edge code at slot pos of a row
  function automatic logic [3:0] tri_edge(input logic [7:0] idx, input logic [3:0] pos);
    logic [ROW_W-1:0] row;
    row = TRI_ROM[idx];
    return row[ROW_W-1-4*int'(pos) -: 4];
  endfunction

  // Cell index clamp to the grid
  function automatic logic [7:0] sat_cell(input logic [7:0] c);
    if (32'(c) > GRID_DIM - 1) return 8'(GRID_DIM - 1);
    return c;
  endfunction

  // One axis of an edge vertex
  function automatic logic [COORD_W-1:0] axis_coord(input logic [7:0] cpos,
                                                    input logic oa, input logic ob,
                                                    input logic [FRAC_W-1:0] frac);
    logic [COORD_W:0] base;
    base = ((COORD_W+1)'(cpos) + (COORD_W+1)'(oa)) << FRAC_BITS;
    if (ob && !oa) base = base + (COORD_W+1)'(frac);
    else if (oa && !ob) base = base - (COORD_W+1)'(frac);
    return base[COORD_W-1:0];
  endfunction

endpackage

[design/mcct_front.sv]
module mcct_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            cell_x,
  input  logic [7:0]            cell_y,
  input  logic [7:0]            cell_z,
  input  logic [7:0][15:0]      corner,
  input  logic [15:0]           iso,
  output logic                  out_valid,
  output mcct_pkg::entry_t      out_entry
);

  localparam int NS = mcct_pkg::FRAC_BITS;
  localparam int NE = mcct_pkg::NUM_EDGES;

  // Per-stage state of the 12 divider lanes
  logic [NS:0]       vld;
  logic [15:0]       rem  [NS+1][NE];
  logic [15:0]       den  [NS+1][NE];
  logic [NS-1:0]     quo  [NS+1][NE];
  logic [NE-1:0]     zro  [NS+1];
  logic [NE-1:0]     sat  [NS+1];
  logic [7:0]        idx  [NS+1];
  logic [7:0]        cx   [NS+1];
  logic [7:0]        cy   [NS+1];
  logic [7:0]        cz   [NS+1];

  // Classification of the incoming cell
  logic [7:0]        idx_in;
  logic [15:0]       an_in [NE];
  logic [15:0]       ad_in [NE];

  always_comb begin
    logic [15:0] va, vb;
    logic [16:0] num, dif;
    for (int c = 0; c < 8; c++) begin
      idx_in[c] = $signed(corner[c]) < $signed(iso);
    end
    for (int e = 0; e < NE; e++) begin
      va = corner[mcct_pkg::EDGE_A[e]];
      vb = corner[mcct_pkg::EDGE_B[e]];
      num = {iso[15], iso} - {va[15], va};
      dif = {vb[15], vb} - {va[15], va};
      an_in[e] = num[16] ? 16'(17'd0 - num) : num[15:0];
      ad_in[e] = dif[16] ? 16'(17'd0 - dif) : dif[15:0];
    end
  end

  // Valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-1:0], accept};
    end
  end

  // Stage 0 load and one quotient bit per later stage
  always_ff @(posedge clk) begin
    logic [16:0] r2;
    if (accept) begin
      idx[0] <= idx_in;
      cx[0]  <= mcct_pkg::sat_cell(cell_x);
      cy[0]  <= mcct_pkg::sat_cell(cell_y);
      cz[0]  <= mcct_pkg::sat_cell(cell_z);
      for (int e = 0; e < NE; e++) begin
        zro[0][e] <= ad_in[e] == 16'd0;
        sat[0][e] <= an_in[e] >= ad_in[e];
        rem[0][e] <= (an_in[e] >= ad_in[e]) ? 16'd0 : an_in[e];
        den[0][e] <= ad_in[e];
        quo[0][e] <= '0;
      end
    end
    for (int s = 1; s <= NS; s++) begin
      idx[s] <= idx[s-1];
      cx[s]  <= cx[s-1];
      cy[s]  <= cy[s-1];
      cz[s]  <= cz[s-1];
      zro[s] <= zro[s-1];
      sat[s] <= sat[s-1];
      for (int e = 0; e < NE; e++) begin
        r2 = {rem[s-1][e], 1'b0};
        den[s][e] <= den[s-1][e];
        if (r2 >= {1'b0, den[s-1][e]}) begin
          rem[s][e] <= 16'(r2 - {1'b0, den[s-1][e]});
          quo[s][e] <= {quo[s-1][e][NS-2:0], 1'b1};
        end else begin
          rem[s][e] <= r2[15:0];
          quo[s][e] <= {quo[s-1][e][NS-2:0], 1'b0};
        end
      end
    end
  end

  // Final fractions, with equal ends and crossings past the far corner settled
  always_comb begin
    out_valid    = vld[NS];
    out_entry.idx = idx[NS];
    out_entry.cx  = cx[NS];
    out_entry.cy  = cy[NS];
    out_entry.cz  = cz[NS];
    for (int e = 0; e < NE; e++) begin
      if (zro[NS][e])
        out_entry.frac[e] = '0;
      else if (sat[NS][e])
        out_entry.frac[e] = mcct_pkg::FRAC_W'(1) << NS;
      else
        out_entry.frac[e] = {1'b0, quo[NS][e]};
    end
  end

endmodule

[design/mcct_queue.sv]
module mcct_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcct_pkg::entry_t   push_entry,
  input  logic               pop,
  output logic               head_valid,
  output mcct_pkg::entry_t   head_entry
);

  mcct_pkg::entry_t                  slots [mcct_pkg::QDEPTH];
  logic [mcct_pkg::QPTR_W-1:0]       wr_ptr;
  logic [mcct_pkg::QPTR_W-1:0]       rd_ptr;
  logic [mcct_pkg::QCNT_W-1:0]       count;

  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == mcct_pkg::QPTR_W'(mcct_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == mcct_pkg::QPTR_W'(mcct_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + mcct_pkg::QCNT_W'(push) - mcct_pkg::QCNT_W'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

[design/mcct_back.sv]
module mcct_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mcct_pkg::entry_t   head_entry,
  output logic               pop,
  output logic               tri_valid,
  output mcct_pkg::tri_t     tri_out
);

  logic [2:0]       tri_k;
  logic [2:0]       ntri;
  logic             emit;
  mcct_pkg::tri_t   tri_next;

  assign ntri = mcct_pkg::tri_count(head_entry.idx);
  assign emit = head_valid && (ntri != 3'd0);
  assign pop  = head_valid && ((ntri == 3'd0) || (tri_k == ntri - 3'd1));

  // Vertices of the current triangle
  always_comb begin
    logic [3:0] pos;
    logic [3:0] ed;
    logic [2:0] a, b;
    logic [mcct_pkg::FRAC_W-1:0] fr;
    for (int v = 0; v < 3; v++) begin
      pos = 4'(tri_k) * 4'd3 + 4'(v);
      ed  = mcct_pkg::tri_edge(head_entry.idx, pos);
      a   = mcct_pkg::EDGE_A[ed];
      b   = mcct_pkg::EDGE_B[ed];
      fr  = head_entry.frac[ed];
      tri_next.vtx[v][0] = mcct_pkg::axis_coord(head_entry.cx, mcct_pkg::OFF_X[a],
                                                mcct_pkg::OFF_X[b], fr);
      tri_next.vtx[v][1] = mcct_pkg::axis_coord(head_entry.cy, mcct_pkg::OFF_Y[a],
                                                mcct_pkg::OFF_Y[b], fr);
      tri_next.vtx[v][2] = mcct_pkg::axis_coord(head_entry.cz, mcct_pkg::OFF_Z[a],
                                                mcct_pkg::OFF_Z[b], fr);
    end
    tri_next.tri_number = tri_k;
    tri_next.last       = pop;
  end

  // Triangle counter and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tri_k     <= '0;
      tri_valid <= 1'b0;
    end else begin
      tri_valid <= emit;
      if (pop)
        tri_k <= '0;
      else if (emit)
        tri_k <= tri_k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) tri_out <= tri_next;
  end

endmodule

[design/marching_cubes_cell_triangulator.sv]
// A cell passes through the divider stages into the cell queue; the emitter registers its triangles onto the outputs.
// A cell enters every cycle while credit remains; the emitter gives one
// triangle per cycle and holds a cell until its last triangle; a cell with none is dropped without a beat.
// At most four cells are in flight between the divider pipeline and the cell queue.
// Reset (rst, synchronous) empties pipeline and queue and sets iso_level to 0.
// Triangles are shown for one cycle under tri_valid; the receiver cannot stall.
module marching_cubes_cell_triangulator (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_write,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          cell_x,
  input  logic [7:0]          cell_y,
  input  logic [7:0]          cell_z,
  input  logic signed [15:0]  corner_val_0,
  input  logic signed [15:0]  corner_val_1,
  input  logic signed [15:0]  corner_val_2,
  input  logic signed [15:0]  corner_val_3,
  input  logic signed [15:0]  corner_val_4,
  input  logic signed [15:0]  corner_val_5,
  input  logic signed [15:0]  corner_val_6,
  input  logic signed [15:0]  corner_val_7,
  output logic                tri_valid,
  output logic [16:0]         v0_x,
  output logic [16:0]         v0_y,
  output logic [16:0]         v0_z,
  output logic [16:0]         v1_x,
  output logic [16:0]         v1_y,
  output logic [16:0]         v1_z,
  output logic [16:0]         v2_x,
  output logic [16:0]         v2_y,
  output logic [16:0]         v2_z,
  output logic [2:0]          tri_number,
  output logic                last
);

  logic [15:0]                  iso_level;
  logic [mcct_pkg::QCNT_W-1:0]  credit;
  logic                         accept;
  logic [7:0][15:0]             corner;
  logic                         fr_valid;
  mcct_pkg::entry_t             fr_entry;
  logic                         head_valid;
  mcct_pkg::entry_t             head_entry;
  logic                         pop;
  mcct_pkg::tri_t               tri_out;

  assign busy   = credit == mcct_pkg::QCNT_W'(mcct_pkg::QDEPTH);
  assign accept = start && !busy;
  assign corner = {corner_val_7, corner_val_6, corner_val_5, corner_val_4,
                   corner_val_3, corner_val_2, corner_val_1, corner_val_0};

  // Iso level register
  always_ff @(posedge clk) begin
    if (rst) iso_level <= '0;
    else if (cfg_write) iso_level <= cfg_data;
  end

  // Cells in flight: one per accepted start beat, released when the emitter drops the cell
  always_ff @(posedge clk) begin
    if (rst) credit <= '0;
    else credit <= credit + mcct_pkg::QCNT_W'(accept) - mcct_pkg::QCNT_W'(pop);
  end

  mcct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .cell_z    (cell_z),
    .corner    (corner),
    .iso       (iso_level),
    .out_valid (fr_valid),
    .out_entry (fr_entry)
  );

  mcct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fr_valid),
    .push_entry (fr_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  mcct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .tri_valid  (tri_valid),
    .tri_out    (tri_out)
  );

  assign v0_x       = tri_out.vtx[0][0];
  assign v0_y       = tri_out.vtx[0][1];
  assign v0_z       = tri_out.vtx[0][2];
  assign v1_x       = tri_out.vtx[1][0];
  assign v1_y       = tri_out.vtx[1][1];
  assign v1_z       = tri_out.vtx[1][2];
  assign v2_x       = tri_out.vtx[2][0];
  assign v2_y       = tri_out.vtx[2][1];
  assign v2_z       = tri_out.vtx[2][2];
  assign tri_number = tri_out.tri_number;
  assign last       = tri_out.last;

endmodule

[design/mcct_checker.sv]
module mcct_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        tri_valid,
  input logic [16:0] v0_x,
  input logic [2:0]  tri_number,
  input logic        last
);

  // A cell's triangles come in consecutive beats with rising numbers
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    tri_valid && !last |=> tri_valid && (tri_number == $past(tri_number) + 3'd1))
    else $error("triangle run broken");

  // A fifth triangle always closes its cell
  a_fifth_is_last: assert property (@(posedge clk) disable iff (rst)
    tri_valid && (tri_number == 3'd4) |-> last)
    else $error("fifth triangle not marked last");

  // Numbers and the x coordinate of vertex 0 stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    tri_valid |-> (tri_number <= 3'd4) && (v0_x <= 17'h10000))
    else $error("triangle beat out of range");

  // Reset leaves room for a new cell
  a_reset_ready: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

endmodule

bind marching_cubes_cell_triangulator mcct_checker u_mcct_checker (.*);

[tb/marching_cubes_cell_triangulator_tb.sv]
module marching_cubes_cell_triangulator_tb;

  typedef logic signed [15:0] corners_t [8];

  // Expected triangles per cell, checked in order against the emitter
  class tri_scoreboard;
    mcct_pkg::tri_t    tri_q[$];
    logic signed [15:0] iso;
    int                errors;
    int                shown;
    bit [2:0]          edge_lo [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
    bit [2:0]          edge_hi [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};
    bit                ox [8] = '{0, 1, 1, 0, 0, 1, 1, 0};
    bit                oy [8] = '{0, 0, 1, 1, 0, 0, 1, 1};
    bit                oz [8] = '{0, 0, 0, 0, 1, 1, 1, 1};

    function logic [16:0] axis_pos(bit [7:0] c, bit oa, bit ob, longint frac);
      longint base;
      base = (longint'(c) + longint'(oa)) << mcct_pkg::FRAC_BITS;
      if (ob && !oa) base += frac;
      else if (oa && !ob) base -= frac;
      return base[16:0];
    endfunction

    // Predict the triangles of one accepted cell
    function void note_cell(bit [7:0] cx, bit [7:0] cy, bit [7:0] cz, corners_t cv);
      logic [7:0]  idx;
      logic [59:0] row;
      logic [16:0] px [12], py [12], pz [12];
      longint      an, ad, frac;
      int          len, ntri, ed;
      mcct_pkg::tri_t t;
      idx = '0;
      for (int c = 0; c < 8; c++) if (cv[c] < iso) idx[c] = 1'b1;
      for (int e = 0; e < 12; e++) begin
        an = longint'(iso) - longint'(cv[edge_lo[e]]);
        ad = longint'(cv[edge_hi[e]]) - longint'(cv[edge_lo[e]]);
        if (an < 0) an = -an;
        if (ad < 0) ad = -ad;
        if (ad == 0) frac = 0;
        else if (an >= ad) frac = 1 << mcct_pkg::FRAC_BITS;
        else frac = (an << mcct_pkg::FRAC_BITS) / ad;
        px[e] = axis_pos(cx, ox[edge_lo[e]], ox[edge_hi[e]], frac);
        py[e] = axis_pos(cy, oy[edge_lo[e]], oy[edge_hi[e]], frac);
        pz[e] = axis_pos(cz, oz[edge_lo[e]], oz[edge_hi[e]], frac);
      end
      row = mcct_pkg::TRI_ROM[idx];
      len = 0;
      while (len < 15 && row[59-4*len -: 4] != 4'hf) len++;
      ntri = len / 3;
      for (int k = 0; k < ntri; k++) begin
        for (int v = 0; v < 3; v++) begin
          ed = row[59-4*(3*k+v) -: 4];
          if (ed > 11) ed = 0;
          t.vtx[v][0] = px[ed];
          t.vtx[v][1] = py[ed];
          t.vtx[v][2] = pz[ed];
        end
        t.tri_number = k[2:0];
        t.last = (k == ntri - 1);
        tri_q = {tri_q, t};
      end
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch %s: expected %0h actual %0h", what, exp_v, act_v);
      end
    endfunction

    // Compare one triangle beat with the oldest expectation
    function void check_tri(mcct_pkg::tri_t act);
      mcct_pkg::tri_t ex;
      if (tri_q.size() == 0) begin
        report("unexpected triangle, vtx0 x", 0, act.vtx[0][0]);
        return;
      end
      ex = tri_q.pop_front();
      for (int v = 0; v < 3; v++)
        for (int a = 0; a < 3; a++)
          if (ex.vtx[v][a] !== act.vtx[v][a])
            report($sformatf("v%0d axis %0d", v, a), ex.vtx[v][a], act.vtx[v][a]);
      if (ex.tri_number !== act.tri_number)
        report("tri_number", ex.tri_number, act.tri_number);
      if (ex.last !== act.last) report("last", ex.last, act.last);
    endfunction
  endclass

  logic        clk, rst, start, busy, cfg_write, tri_valid, last;
  logic [15:0] cfg_data;
  logic [7:0]  cell_x, cell_y, cell_z;
  corners_t    cv;
  logic [16:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
  logic [2:0]  tri_number;
  tri_scoreboard sb = new();
  int          burst_left;

  marching_cubes_cell_triangulator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
    .corner_val_0(cv[0]), .corner_val_1(cv[1]), .corner_val_2(cv[2]),
    .corner_val_3(cv[3]), .corner_val_4(cv[4]), .corner_val_5(cv[5]),
    .corner_val_6(cv[6]), .corner_val_7(cv[7]),
    .tri_valid(tri_valid),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z), .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .tri_number(tri_number), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    mcct_pkg::tri_t act;
    if (!rst && tri_valid) begin
      act.vtx = '{'{v2_z, v2_y, v2_x}, '{v1_z, v1_y, v1_x}, '{v0_z, v0_y, v0_x}};
      act.tri_number = tri_number;
      act.last = last;
      sb.check_tri(act);
    end
  end

  // Send one cell; called at a falling edge, returns at a falling edge
  task automatic send_cell(bit [7:0] cx, bit [7:0] cy, bit [7:0] cz, corners_t c);
    cell_x = cx;
    cell_y = cy;
    cell_z = cz;
    cv = c;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cell(cx, cy, cz, c);
    @(negedge clk);
  endtask

  // Burst/gap pacing of the sender
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    start = 1'b0;
    repeat ($urandom_range(0, 12)) @(negedge clk);
    burst_left = $urandom_range(0, 20);
  endtask

  // Hold off until every expected triangle is out and the pipeline is empty
  task automatic drain();
    start = 1'b0;
    while (sb.tri_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_iso(logic [15:0] v);
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.iso = v;
  endtask

  function automatic logic signed [15:0] near_iso();
    int v;
    if ($urandom_range(0, 9) < 2) return 16'($urandom());
    v = int'(sb.iso) + $urandom_range(0, 1023) - 512;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic random_cells(int n);
    corners_t c;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 8; k++) c[k] = near_iso();
      send_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), c);
      pace();
    end
  endtask

  // Directed cells: extremes, empty and full cubes, single corners, big spans
  task automatic directed_cells();
    corners_t c;
    c = '{default: 16'sh0000};
    send_cell(8'd0, 8'd0, 8'd0, c);
    c = '{default: -16'sd1};
    send_cell(8'd255, 8'd255, 8'd255, c);
    for (int k = 0; k < 8; k++) begin
      c = '{default: 16'sh7fff};
      c[k] = 16'sh8000;
      send_cell(8'd255, 8'd0, 8'd255, c);
    end
    for (int k = 0; k < 8; k++) begin
      c = '{default: 16'sh8000};
      c[k] = 16'sh7fff;
      send_cell(8'd0, 8'd255, 8'd0, c);
    end
    c = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_cell(8'hAA, 8'h55, 8'hFF, c);
    c = '{-16'sd1, 16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1};
    send_cell(8'h55, 8'hAA, 8'h00, c);
    c = '{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd256};
    send_cell(8'd128, 8'd127, 8'd1, c);
    start = 1'b0;
  endtask

  initial begin
    logic [15:0] iso_set [6];
    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    cell_x = '0;
    cell_y = '0;
    cell_z = '0;
    cv = '{default: 16'sh0000};
    burst_left = 0;
    sb.iso = 16'sh0000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_cells();
    drain();
    iso_set = '{16'h8000, 16'h7fff, 16'($urandom()), 16'h0100, 16'hff00, 16'h0000};
    foreach (iso_set[p]) begin
      write_iso(iso_set[p]);
      random_cells(78);
      drain();
    end

    if (sb.errors == 0 && sb.tri_q.size() == 0)
      $display("marching_cubes_cell_triangulator_tb: clean");
    else
      $display("marching_cubes_cell_triangulator_tb: errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("marching_cubes_cell_triangulator_tb: errors");
    $finish;
  end

endmodule

[marching_cubes_cell_triangulator.f]
design/mcct_pkg.sv
design/mcct_front.sv
design/mcct_queue.sv
design/mcct_back.sv
design/marching_cubes_cell_triangulator.sv
design/mcct_checker.sv
tb/marching_cubes_cell_triangulator_tb.sv
